@@ rtl/lpgr_pkg.sv @@
// Package: payload types and codes for the LED panel gamma remap block.
`default_nettype none
package lpgr_pkg;

    localparam int unsigned GAMMA_DEPTH = 768;
    localparam int unsigned GAMMA_AW    = 10;
    localparam int unsigned BANK_COUNT  = 3;

    localparam logic       MODE_LOAD  = 1'b0;
    localparam logic       MODE_PIXEL = 1'b1;

    localparam logic [1:0] CHAN_RED   = 2'd0;
    localparam logic [1:0] CHAN_GREEN = 2'd1;
    localparam logic [1:0] CHAN_BLUE  = 2'd2;
    localparam logic [1:0] CHAN_NONE  = 2'd3;

    localparam logic [2:0] PLANE_UP_RED   = 3'd0;
    localparam logic [2:0] PLANE_UP_GREEN = 3'd1;
    localparam logic [2:0] PLANE_UP_BLUE  = 3'd2;
    localparam logic [2:0] PLANE_LO_RED   = 3'd3;
    localparam logic [2:0] PLANE_LO_GREEN = 3'd4;
    localparam logic [2:0] PLANE_LO_BLUE  = 3'd5;

    localparam logic [1:0] BANK_RESET = 2'd1;
    localparam logic [1:0] BANK_LAST  = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [1:0]  table_channel;
        logic [7:0]  table_level;
        logic [15:0] table_value;
        logic [7:0]  column;
        logic [5:0]  scan_row;
        logic [7:0]  upper_red;
        logic [7:0]  upper_green;
        logic [7:0]  upper_blue;
        logic [7:0]  lower_red;
        logic [7:0]  lower_green;
        logic [7:0]  lower_blue;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  write_bank;
        logic [5:0]  write_row;
        logic [3:0]  column_in_group;
        logic [2:0]  colour_plane;
        logic [3:0]  column_group;
        logic [15:0] pwm_value;
        logic        last_of_run;
        logic        frame_done;
    } t_out_item;

    // address and flags of one buffer write, waiting on the gamma read
    typedef struct packed {
        logic [1:0] write_bank;
        logic [5:0] write_row;
        logic [3:0] column_in_group;
        logic [2:0] colour_plane;
        logic [3:0] column_group;
        logic       last_of_run;
        logic       frame_done;
    } t_wr_meta;

endpackage
`default_nettype wire

@@ rtl/lpgr_in_if.sv @@
// Interface: input channel carrying table loads and pixel pairs.
`default_nettype none
interface lpgr_in_if;
    import lpgr_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/lpgr_out_if.sv @@
// Interface: output channel carrying frame-buffer writes.
`default_nettype none
interface lpgr_out_if;
    import lpgr_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/lpgr_ram.sv @@
// Generic simple dual-port RAM with registered, enable-held read data.
`default_nettype none
module lpgr_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // read-first: a read and write to one entry in a cycle return the old data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end
endmodule
`default_nettype wire

@@ rtl/led_panel_gamma_remap.sv @@
// LED panel gamma remap: pixel pairs in, gamma-corrected frame-buffer writes out.
//
// Channels: i_pix takes one transaction per item. mode 0 loads one 16-bit entry
// of the 3 x 256 gamma store (channel 3 is dropped) and yields nothing. mode 1
// carries a pixel pair and yields six transactions on o_wr: upper R, G, B to
// planes 0-2, then lower R, G, B to planes 3-5, each addressed by bank, row,
// column mod 16 and column div 16. The sixth write of the pair at the last
// column of the last scan row carries frame_done; the fill bank then advances
// modulo 3.
// Sequencing: each pixel pair takes six gamma store reads through the single read
// port; a table load issues no read. The next item is taken in the cycle the
// sixth read of the current pair issues.
// Path: the first write of a pair reaches o_wr through the pair registers, the
// gamma read stage and then the output register.
// Reset: fill bank returns to 1 and the pipeline empties; gamma store contents
// are undefined until loaded. When o_wr stalls, one write waits in the output
// register, one in the RAM read stage, and reads pause until space frees up.
`default_nettype none
module led_panel_gamma_remap #(
    parameter int unsigned PANEL_COLUMNS = 128,
    parameter int unsigned SCAN_ROWS     = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lpgr_in_if.sink    i_pix,
    lpgr_out_if.source o_wr
);
    import lpgr_pkg::*;

    localparam logic [7:0] COL_LAST = 8'(PANEL_COLUMNS - 1);
    localparam logic [5:0] ROW_LAST = 6'(SCAN_ROWS - 1);

    // pixel pair held while its six reads issue
    logic                r_busy;
    logic [2:0]          r_plane;
    logic [7:0]          r_column;
    logic [5:0]          r_row;
    logic [7:0]          r_lvl [6];
    logic [1:0]          r_bank;
    logic [1:0]          n_bank;

    // RAM read stage and output register
    logic                r_s1_valid;
    t_wr_meta            r_s1_meta;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                w_accept;
    logic                w_s1_adv;
    logic                w_issue;
    logic                w_last_issue;
    logic                w_closes;
    logic [1:0]          w_chan;
    logic [7:0]          w_level;
    logic [GAMMA_AW-1:0] w_raddr;
    logic                w_we;
    logic [15:0]         w_rdata;
    t_wr_meta            w_meta;

    assign w_s1_adv     = r_s1_valid && (!r_out_valid || o_wr.ready);
    assign w_issue      = r_busy && (!r_s1_valid || w_s1_adv);
    assign w_last_issue = w_issue && (r_plane == PLANE_LO_BLUE);
    assign i_pix.ready  = !r_busy || w_last_issue;
    assign w_accept     = i_pix.valid && i_pix.ready;
    assign w_closes     = (r_column == COL_LAST) && (r_row == ROW_LAST);
    assign n_bank       = (r_bank == BANK_LAST) ? 2'd0 : r_bank + 2'd1;

    always_comb begin
        unique case (r_plane)
            PLANE_UP_RED:   w_chan = CHAN_RED;
            PLANE_UP_GREEN: w_chan = CHAN_GREEN;
            PLANE_UP_BLUE:  w_chan = CHAN_BLUE;
            PLANE_LO_RED:   w_chan = CHAN_RED;
            PLANE_LO_GREEN: w_chan = CHAN_GREEN;
            PLANE_LO_BLUE:  w_chan = CHAN_BLUE;
            default:        w_chan = CHAN_RED;
        endcase
        w_level = (r_plane <= PLANE_LO_BLUE) ? r_lvl[r_plane] : 8'd0;
    end

    assign w_raddr = {w_chan, w_level};
    assign w_we    = w_accept && (i_pix.data.mode == MODE_LOAD)
                     && (i_pix.data.table_channel != CHAN_NONE);

    always_comb begin
        w_meta.write_bank      = r_bank;
        w_meta.write_row       = r_row;
        w_meta.column_in_group = r_column[3:0];
        w_meta.colour_plane    = r_plane;
        w_meta.column_group    = r_column[7:4];
        w_meta.last_of_run     = (r_plane == PLANE_LO_BLUE);
        w_meta.frame_done      = (r_plane == PLANE_LO_BLUE) && w_closes;
    end

    lpgr_ram #(
        .WIDTH(16),
        .DEPTH(GAMMA_DEPTH)
    ) u_gamma (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr({i_pix.data.table_channel, i_pix.data.table_level}),
        .i_wdata(i_pix.data.table_value),
        .i_re   (w_issue),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_plane <= PLANE_UP_RED;
            r_bank  <= BANK_RESET;
        end else begin
            // while busy, a new pair can only be taken alongside the last read of the old one
            if (w_accept && (i_pix.data.mode == MODE_PIXEL)) begin
                r_busy  <= 1'b1;
                r_plane <= PLANE_UP_RED;
            end else if (w_issue) begin
                if (r_plane == PLANE_LO_BLUE) begin
                    r_busy  <= 1'b0;
                    r_plane <= PLANE_UP_RED;
                end else begin
                    r_plane <= r_plane + 3'd1;
                end
            end
            if (w_last_issue && w_closes) begin
                r_bank <= n_bank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_pix.data.mode == MODE_PIXEL)) begin
            r_column <= i_pix.data.column;
            r_row    <= i_pix.data.scan_row;
            r_lvl[0] <= i_pix.data.upper_red;
            r_lvl[1] <= i_pix.data.upper_green;
            r_lvl[2] <= i_pix.data.upper_blue;
            r_lvl[3] <= i_pix.data.lower_red;
            r_lvl[4] <= i_pix.data.lower_green;
            r_lvl[5] <= i_pix.data.lower_blue;
        end
    end

    // read stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_issue) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_wr.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_meta <= w_meta;
        end
        if (w_s1_adv) begin
            r_out.write_bank      <= r_s1_meta.write_bank;
            r_out.write_row       <= r_s1_meta.write_row;
            r_out.column_in_group <= r_s1_meta.column_in_group;
            r_out.colour_plane    <= r_s1_meta.colour_plane;
            r_out.column_group    <= r_s1_meta.column_group;
            r_out.pwm_value       <= w_rdata;
            r_out.last_of_run     <= r_s1_meta.last_of_run;
            r_out.frame_done      <= r_s1_meta.frame_done;
        end
    end

    assign o_wr.valid = r_out_valid;
    assign o_wr.data  = r_out;

    a_issue_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |=> r_s1_valid)
        else $error("gamma read issued without landing in read stage");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr.valid && o_wr.data.frame_done) |-> o_wr.data.last_of_run)
        else $error("frame_done on a write that is not last of its pair");

    a_bank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bank != 2'd3)
        else $error("fill bank out of range");

    a_accept_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_busy) |-> w_last_issue)
        else $error("item taken while a pixel pair still has reads to issue");
endmodule
`default_nettype wire

@@ test/tb.sv @@
// Testbench: randomized table loads and pixel pairs, with checked frame-buffer writes.
`default_nettype none
module tb;
    import lpgr_pkg::*;

    localparam int unsigned PANEL_COLUMNS = 128;
    localparam int unsigned SCAN_ROWS     = 16;
    localparam int unsigned RANDOM_ITEMS  = 412;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned DRAIN_CYCLES  = 20;

    localparam logic [7:0] COL_LAST = 8'(PANEL_COLUMNS - 1);
    localparam logic [5:0] ROW_LAST = 6'(SCAN_ROWS - 1);

    localparam logic [1:0] PLANE_CHAN [6] = '{CHAN_RED, CHAN_GREEN, CHAN_BLUE,
                                              CHAN_RED, CHAN_GREEN, CHAN_BLUE};
    localparam logic [2:0] PLANE_CODE [6] = '{PLANE_UP_RED, PLANE_UP_GREEN, PLANE_UP_BLUE,
                                              PLANE_LO_RED, PLANE_LO_GREEN, PLANE_LO_BLUE};

    logic i_clk = 1'b0;
    logic i_rst_n;

    lpgr_in_if  pix_if ();
    lpgr_out_if wr_if ();

    led_panel_gamma_remap #(
        .PANEL_COLUMNS(PANEL_COLUMNS),
        .SCAN_ROWS    (SCAN_ROWS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_if),
        .o_wr   (wr_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // stimulus and generation-time bookkeeping of which gamma levels are loaded
    t_in_item    item_queue [$];
    logic [7:0]  level_list [3][$];
    bit          level_seen [3][256];
    int unsigned total_items;

    // shadow of the block state and the writes it owes
    logic [15:0] gamma_shadow [GAMMA_DEPTH];
    logic [1:0]  shadow_bank;
    t_out_item   pending_writes [$];

    int unsigned cycle_count;
    int unsigned items_taken;
    int unsigned loads_taken;
    int unsigned pairs_taken;
    int unsigned writes_seen;
    int unsigned frames_closed;
    int unsigned mismatch_count;
    logic        in_fire;
    logic        wr_fire;
    int          gap_left;
    int          stall_left;

    function automatic int idle_draw();
        // one window in four, chosen by bits 9:8 of the cycle count, runs with no idling on either side
        if (cycle_count[9:8] == 2'd0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic t_in_item noise_item();
        t_in_item it;
        it.mode          = 1'($urandom_range(0, 1));
        it.table_channel = 2'($urandom_range(0, 3));
        it.table_level   = 8'($urandom_range(0, 255));
        it.table_value   = 16'($urandom_range(0, 65535));
        it.column        = 8'($urandom_range(0, 255));
        it.scan_row      = 6'($urandom_range(0, 63));
        it.upper_red     = 8'($urandom_range(0, 255));
        it.upper_green   = 8'($urandom_range(0, 255));
        it.upper_blue    = 8'($urandom_range(0, 255));
        it.lower_red     = 8'($urandom_range(0, 255));
        it.lower_green   = 8'($urandom_range(0, 255));
        it.lower_blue    = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic queue_load(input logic [1:0] ch, input logic [7:0] lvl,
                              input logic [15:0] val);
        t_in_item it;
        it               = noise_item();
        it.mode          = MODE_LOAD;
        it.table_channel = ch;
        it.table_level   = lvl;
        it.table_value   = val;
        item_queue.push_back(it);
        if (ch != CHAN_NONE && !level_seen[ch][lvl]) begin
            level_seen[ch][lvl] = 1'b1;
            level_list[ch].push_back(lvl);
        end
    endtask

    task automatic queue_pair(input logic [7:0] col, input logic [5:0] row,
                              input logic [7:0] ur, input logic [7:0] ug, input logic [7:0] ub,
                              input logic [7:0] lr, input logic [7:0] lg, input logic [7:0] lb);
        t_in_item it;
        it             = noise_item();
        it.mode        = MODE_PIXEL;
        it.column      = col;
        it.scan_row    = row;
        it.upper_red   = ur;
        it.upper_green = ug;
        it.upper_blue  = ub;
        it.lower_red   = lr;
        it.lower_green = lg;
        it.lower_blue  = lb;
        item_queue.push_back(it);
    endtask

    function automatic logic [7:0] pick_level(input logic [1:0] ch);
        return level_list[ch][$urandom_range(0, level_list[ch].size() - 1)];
    endfunction

    task automatic queue_random_pair();
        logic [7:0] col;
        logic [5:0] row;
        case ($urandom_range(0, 7))
            0: begin
                col = COL_LAST;
                row = ROW_LAST;
            end
            1: begin
                col = COL_LAST;
                row = 6'($urandom_range(0, SCAN_ROWS - 1));
            end
            2: begin
                col = 8'($urandom_range(0, PANEL_COLUMNS - 1));
                row = ROW_LAST;
            end
            3: begin
                col = 8'($urandom_range(PANEL_COLUMNS, 255));
                row = 6'($urandom_range(0, 63));
            end
            4: begin
                col = 8'($urandom_range(0, 255));
                row = 6'($urandom_range(SCAN_ROWS, 63));
            end
            default: begin
                col = 8'($urandom_range(0, PANEL_COLUMNS - 1));
                row = 6'($urandom_range(0, SCAN_ROWS - 1));
            end
        endcase
        queue_pair(col, row,
                   pick_level(CHAN_RED), pick_level(CHAN_GREEN), pick_level(CHAN_BLUE),
                   pick_level(CHAN_RED), pick_level(CHAN_GREEN), pick_level(CHAN_BLUE));
    endtask

    // one transaction in: update the shadow store or queue the six buffer writes
    task automatic predict_buffer_writes(input t_in_item it);
        logic [7:0] lvl [6];
        t_out_item  wr;
        logic       closes;
        if (it.mode == MODE_LOAD) begin
            loads_taken++;
            if (it.table_channel != CHAN_NONE)
                gamma_shadow[{it.table_channel, it.table_level}] = it.table_value;
            return;
        end
        pairs_taken++;
        lvl    = '{it.upper_red, it.upper_green, it.upper_blue,
                   it.lower_red, it.lower_green, it.lower_blue};
        closes = (it.column == COL_LAST) && (it.scan_row == ROW_LAST);
        for (int p = 0; p < 6; p++) begin
            wr.write_bank      = shadow_bank;
            wr.write_row       = it.scan_row;
            wr.column_in_group = it.column[3:0];
            wr.colour_plane    = PLANE_CODE[p];
            wr.column_group    = it.column[7:4];
            wr.pwm_value       = gamma_shadow[{PLANE_CHAN[p], lvl[p]}];
            wr.last_of_run     = (p == 5);
            wr.frame_done      = (p == 5) && closes;
            pending_writes.push_back(wr);
        end
        if (closes)
            shadow_bank = (shadow_bank == BANK_LAST) ? 2'd0 : shadow_bank + 2'd1;
    endtask

    function automatic void check_field(input string fname, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: write %0d %s expected %0d got %0d",
                     $time, writes_seen, fname, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        t_out_item exp_wr;
        t_out_item act_wr;
        cycle_count++;
        in_fire <= i_rst_n && pix_if.valid && pix_if.ready;
        wr_fire <= i_rst_n && wr_if.valid && wr_if.ready;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            items_taken++;
            predict_buffer_writes(pix_if.data);
        end
        if (i_rst_n && wr_if.valid && wr_if.ready) begin
            act_wr = wr_if.data;
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected write bank %0d row %0d plane %0d value %0h",
                         $time, act_wr.write_bank, act_wr.write_row,
                         act_wr.colour_plane, act_wr.pwm_value);
                mismatch_count++;
            end else begin
                exp_wr = pending_writes.pop_front();
                check_field("write_bank", 16'(exp_wr.write_bank), 16'(act_wr.write_bank));
                check_field("write_row", 16'(exp_wr.write_row), 16'(act_wr.write_row));
                check_field("column_in_group", 16'(exp_wr.column_in_group),
                            16'(act_wr.column_in_group));
                check_field("colour_plane", 16'(exp_wr.colour_plane),
                            16'(act_wr.colour_plane));
                check_field("column_group", 16'(exp_wr.column_group),
                            16'(act_wr.column_group));
                check_field("pwm_value", exp_wr.pwm_value, act_wr.pwm_value);
                check_field("last_of_run", 16'(exp_wr.last_of_run),
                            16'(act_wr.last_of_run));
                check_field("frame_done", 16'(exp_wr.frame_done), 16'(act_wr.frame_done));
            end
            writes_seen++;
            if (act_wr.frame_done)
                frames_closed++;
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d writes still owed",
                     cycle_count, pending_writes.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // input driver: holds each transaction until taken, then idles a drawn gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (!pix_if.valid || in_fire) begin
            if (in_fire)
                gap_left = idle_draw();
            if (gap_left > 0) begin
                gap_left--;
                pix_if.valid <= 1'b0;
            end else if (item_queue.size() > 0) begin
                pix_if.data  <= item_queue.pop_front();
                pix_if.valid <= 1'b1;
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // output back-pressure: a drawn stall after every accepted write
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            wr_if.ready <= 1'b0;
        end else begin
            if (wr_fire)
                stall_left = idle_draw();
            if (stall_left > 0) begin
                stall_left--;
                wr_if.ready <= 1'b0;
            end else begin
                wr_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned counted;
        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        wr_if.ready  = 1'b0;
        i_rst_n      = 1'b0;
        shadow_bank  = BANK_RESET;
        gap_left     = 0;
        stall_left   = 0;

        // directed: table extremes, ignored channel, frame close and its near misses
        queue_load(CHAN_RED, 8'd0, 16'h0000);
        queue_load(CHAN_GREEN, 8'd0, 16'hFFFF);
        queue_load(CHAN_BLUE, 8'd0, 16'h8001);
        queue_load(CHAN_RED, 8'd255, 16'hFFFF);
        queue_load(CHAN_GREEN, 8'd255, 16'h0000);
        queue_load(CHAN_BLUE, 8'd255, 16'h7FFE);
        queue_load(CHAN_NONE, 8'd0, 16'h1234);
        queue_load(CHAN_NONE, 8'd255, 16'hFFFF);
        queue_pair(8'd0, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_pair(8'd255, 6'd63, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
        queue_pair(8'd0, 6'd63, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
        queue_pair(COL_LAST, ROW_LAST - 6'd1, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
        queue_pair(COL_LAST - 8'd1, ROW_LAST, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
        queue_pair(COL_LAST, ROW_LAST, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255);
        queue_pair(8'(PANEL_COLUMNS), ROW_LAST, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0);
        queue_pair(COL_LAST, 6'(SCAN_ROWS), 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255);
        queue_pair(COL_LAST, ROW_LAST, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
        queue_pair(COL_LAST, ROW_LAST, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        queue_load(CHAN_RED, 8'd0, 16'h5A5A);
        queue_pair(8'd15, 6'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_pair(8'd240, 6'd32, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0);

        // random: mostly pixel pairs over loaded levels, some table rewrites
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0: begin
                    queue_load(CHAN_NONE, 8'($urandom_range(0, 255)),
                               16'($urandom_range(0, 65535)));
                    counted++;
                end
                1, 2, 3, 4, 5: begin
                    queue_load(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                               16'($urandom_range(0, 65535)));
                    counted++;
                end
                default: begin
                    queue_random_pair();
                    counted++;
                end
            endcase
        end
        total_items = item_queue.size();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (items_taken < total_items || pending_writes.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d transactions in: %0d table loads, %0d pixel pairs",
                 items_taken, loads_taken, pairs_taken);
        $display("%0d buffer writes checked, %0d frames closed, %0d cycles",
                 writes_seen, frames_closed, cycle_count);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
